[hdl/kdt_pkg.sv]
// Shared constants, codes and types for the keepalive deadline table.
package kdt_pkg;

  // Table geometry
  localparam int unsigned TABLE_DEPTH = 16;
  localparam int unsigned JOB_COUNT   = 64;
  localparam int unsigned JOB_W       = 6;
  localparam int unsigned IDX_W       = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(TABLE_DEPTH + 1);

  // Arithmetic constants
  localparam logic [9:0]  MS_PER_S       = 10'd1000;
  localparam logic [30:0] INTERVAL_MAX   = 31'h7FFF_FFFF;
  localparam logic [30:0] FALLBACK_RESET = 31'd10000;
  localparam int unsigned PROD_W         = 42;

  // Input word selector
  typedef enum logic [1:0] {
    ACT_ADD    = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_WAKE   = 2'd2,
    ACT_RSVD   = 2'd3
  } action_e;

  // Output word kind
  typedef enum logic {
    KIND_NOTICE  = 1'b0,
    KIND_SUMMARY = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_FULL    = 2'd1,
    STAT_NOTHING = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    TMR_LEAVE   = 2'd0,
    TMR_DISABLE = 2'd1,
    TMR_ENABLE  = 2'd2
  } timer_cmd_e;

  // Sequencer states, one-hot
  typedef enum logic [8:0] {
    ST_IDLE    = 9'b0_0000_0001,
    ST_ADD     = 9'b0_0000_0010,
    ST_RM_SCAN = 9'b0_0000_0100,
    ST_MIN     = 9'b0_0000_1000,
    ST_GAP     = 9'b0_0001_0000,
    ST_MUL     = 9'b0_0010_0000,
    ST_SAT     = 9'b0_0100_0000,
    ST_EXPIRE  = 9'b0_1000_0000,
    ST_SUMMARY = 9'b1_0000_0000
  } state_e;

endpackage

[hdl/keepalive_deadline_table_unit.sv]
// Keepalive deadline table: ordered watchdog entries with wakeup timer control.
//
// Usage: each input word carries an action on s_axis_tuser (add, remove, wake)
// and the job, throttle, wall time and running mask on s_axis_tdata. The block
// answers with zero or more expiry notices (m_axis_tuser = 0), each for one
// expired entry in table order, then one closing summary (m_axis_tuser = 1,
// m_axis_tlast = 1) with the status, timer command and new timer interval.
// One input word is in work at a time; s_axis_tready is low until the summary
// is loaded into the output register. A notice is loaded in the expiry scan
// cycle of its entry. The single table read port is walked one entry per
// cycle by the minimum search, the match scan and the expiry scan, the last
// stalling on an expired entry while the receiver holds off; the gap subtract,
// the seconds-to-ms multiply and the saturation are each a registered state.
// The register cfg_wdata_i sets the fallback interval and is to be written by
// the user only while the block is idle; the block itself does not enforce it.
// Reset empties the table, clears the remembered interval and sets the
// fallback to 10000 ms. A stalled receiver holds the output register and
// the sequencer waits before each notice and before the summary.
module keepalive_deadline_table_unit
  import kdt_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  // Configuration: fallback_interval_ms
  input  logic         cfg_we_i,
  input  logic [30:0]  cfg_wdata_i,
  // Input words
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // tuser: action[1:0]
  input  logic [1:0]   s_axis_tuser_i,
  // tdata: job_id[5:0], keep_always[6], throttle_seconds[22:7],
  //        now_seconds[54:23], running_mask[118:55], zero fill[119]
  input  logic [119:0] s_axis_tdata_i,
  // Output words
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // tuser: kind[0]
  output logic         m_axis_tuser_o,
  // tdata: expired_job[5:0], restart[6], status[8:7], timer_command[10:9],
  //        interval_ms[41:11], zero fill[47:42]
  output logic [47:0]  m_axis_tdata_o,
  output logic         m_axis_tlast_o
);

  // Sequencer and item registers
  state_e            state_q, state_d;
  logic [1:0]        act_q;
  logic [JOB_W-1:0]  job_q;
  logic              keep_q;
  logic [15:0]       thr_q;
  logic [31:0]       now_q;
  logic [63:0]       run_q;

  // Table storage
  logic [JOB_W-1:0]  tab_job_q [TABLE_DEPTH];
  logic [31:0]       tab_dl_q  [TABLE_DEPTH];
  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  idx_q, idx_d;

  // Timer datapath
  logic [30:0]       fallback_q;
  logic [30:0]       cur_int_q, cur_int_d;
  logic [31:0]       lo_q, lo_d;
  logic [31:0]       gap_q, gap_d;
  logic              gap_pos_q, gap_pos_d;
  logic [PROD_W-1:0] prod_q, prod_d;
  logic [1:0]        status_q, status_d;
  logic [1:0]        cmd_q, cmd_d;
  logic [30:0]       ms_q, ms_d;

  // Output register
  logic              m_valid_q;
  logic              m_kind_q;
  logic [JOB_W-1:0]  m_job_q;
  logic              m_rst_q;
  logic [1:0]        m_status_q;
  logic [1:0]        m_cmd_q;
  logic [30:0]       m_ms_q;
  logic              m_last_q;

  // Control strobes
  logic              in_take;
  logic              out_free;
  logic              do_insert;
  logic              do_delete;
  logic [CNT_W-1:0]  del_idx;
  logic              emit_notice;
  logic              emit_summary;
  logic              idx_end;
  logic [JOB_W-1:0]  rd_job;
  logic [31:0]       rd_dl;
  logic [32:0]       dl_sum;
  logic [31:0]       dl_sat;
  logic [32:0]       gap_full;
  logic [30:0]       sat_val;
  logic              job_ok;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_take         = s_axis_tvalid_i & s_axis_tready_o;
  assign out_free        = ~m_valid_q | m_axis_tready_i;
  assign idx_end         = (idx_q == count_q);

  // Single table read port at the scan index
  assign rd_job = tab_job_q[idx_q[IDX_W-1:0]];
  assign rd_dl  = tab_dl_q[idx_q[IDX_W-1:0]];

  // Saturating deadline for an add
  assign dl_sum = {1'b0, now_q} + {17'b0, thr_q};
  assign dl_sat = dl_sum[32] ? 32'hFFFF_FFFF : dl_sum[31:0];

  assign gap_full = {1'b0, lo_q} - {1'b0, now_q};
  assign job_ok   = ({1'b0, job_q} < 7'(JOB_COUNT));

  // Pick the interval from the registered product or the fallback
  always_comb begin
    if (gap_pos_q) begin
      sat_val = (prod_q > PROD_W'(INTERVAL_MAX)) ? INTERVAL_MAX : prod_q[30:0];
    end else begin
      sat_val = (fallback_q == '0) ? 31'd1 : fallback_q;
    end
  end

  // Sequencer
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    idx_d        = idx_q;
    cur_int_d    = cur_int_q;
    lo_d         = lo_q;
    gap_d        = gap_q;
    gap_pos_d    = gap_pos_q;
    prod_d       = prod_q;
    status_d     = status_q;
    cmd_d        = cmd_q;
    ms_d         = ms_q;
    do_insert    = 1'b0;
    do_delete    = 1'b0;
    del_idx      = idx_q;
    emit_notice  = 1'b0;
    emit_summary = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_take) begin
          status_d = STAT_NOTHING;
          cmd_d    = TMR_LEAVE;
          ms_d     = '0;
          idx_d    = '0;
          unique case (action_e'(s_axis_tuser_i))
            ACT_ADD:    state_d = ST_ADD;
            ACT_REMOVE: state_d = ST_RM_SCAN;
            ACT_WAKE:   state_d = ST_MIN;
            default:    state_d = ST_SUMMARY;
          endcase
        end
      end

      ST_ADD: begin
        if (!(job_ok && keep_q)) begin
          state_d = ST_SUMMARY;
        end else if (count_q >= CNT_W'(TABLE_DEPTH)) begin
          status_d = STAT_FULL;
          state_d  = ST_SUMMARY;
        end else begin
          do_insert = 1'b1;
          count_d   = count_q + 1'b1;
          idx_d     = '0;
          state_d   = ST_MIN;
        end
      end

      ST_RM_SCAN: begin
        if (!job_ok || idx_end) begin
          state_d = ST_SUMMARY;
        end else if (rd_job == job_q) begin
          do_delete = 1'b1;
          count_d   = count_q - 1'b1;
          idx_d     = '0;
          state_d   = ST_MIN;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end

      // Walk the table for the earliest deadline
      ST_MIN: begin
        status_d = STAT_OK;
        if (idx_end) begin
          if (count_q == '0) begin
            cmd_d     = TMR_DISABLE;
            cur_int_d = '0;
            idx_d     = '0;
            state_d   = (act_q == ACT_WAKE) ? ST_EXPIRE : ST_SUMMARY;
          end else begin
            state_d = ST_GAP;
          end
        end else begin
          if (idx_q == '0 || rd_dl < lo_q) begin
            lo_d = rd_dl;
          end
          idx_d = idx_q + 1'b1;
        end
      end

      ST_GAP: begin
        gap_d     = gap_full[31:0];
        gap_pos_d = ~gap_full[32] & (gap_full != '0);
        state_d   = ST_MUL;
      end

      ST_MUL: begin
        prod_d  = gap_q * MS_PER_S;
        state_d = ST_SAT;
      end

      // Reprogram the timer only on a changed interval
      ST_SAT: begin
        if (sat_val == cur_int_q) begin
          cmd_d = TMR_LEAVE;
        end else begin
          cmd_d     = TMR_ENABLE;
          ms_d      = sat_val;
          cur_int_d = sat_val;
        end
        idx_d   = '0;
        state_d = (act_q == ACT_WAKE) ? ST_EXPIRE : ST_SUMMARY;
      end

      // Emit and drop expired entries, keep the rest in order
      ST_EXPIRE: begin
        if (idx_end) begin
          state_d = ST_SUMMARY;
        end else if (now_q >= rd_dl) begin
          if (out_free) begin
            emit_notice = 1'b1;
            do_delete   = 1'b1;
            count_d     = count_q - 1'b1;
          end
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end

      ST_SUMMARY: begin
        if (out_free) begin
          emit_summary = 1'b1;
          state_d      = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      count_q    <= '0;
      cur_int_q  <= '0;
      fallback_q <= FALLBACK_RESET;
      m_valid_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      cur_int_q <= cur_int_d;
      if (cfg_we_i) begin
        fallback_q <= cfg_wdata_i;
      end
      if (emit_notice || emit_summary) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    lo_q      <= lo_d;
    gap_q     <= gap_d;
    gap_pos_q <= gap_pos_d;
    prod_q    <= prod_d;
    status_q  <= status_d;
    cmd_q     <= cmd_d;
    ms_q      <= ms_d;
    if (in_take) begin
      act_q  <= s_axis_tuser_i;
      job_q  <= s_axis_tdata_i[5:0];
      keep_q <= s_axis_tdata_i[6];
      thr_q  <= s_axis_tdata_i[22:7];
      now_q  <= s_axis_tdata_i[54:23];
      run_q  <= s_axis_tdata_i[118:55];
    end
  end

  // Table update: insert at head or close the gap at the delete index
  always_ff @(posedge clk_i) begin
    if (do_insert) begin
      for (int k = TABLE_DEPTH - 1; k > 0; k--) begin
        tab_job_q[k] <= tab_job_q[k-1];
        tab_dl_q[k]  <= tab_dl_q[k-1];
      end
      tab_job_q[0] <= job_q;
      tab_dl_q[0]  <= dl_sat;
    end else if (do_delete) begin
      for (int k = 0; k < TABLE_DEPTH - 1; k++) begin
        if (k >= int'(del_idx)) begin
          tab_job_q[k] <= tab_job_q[k+1];
          tab_dl_q[k]  <= tab_dl_q[k+1];
        end
      end
    end
  end

  // Load the output register
  always_ff @(posedge clk_i) begin
    if (emit_notice) begin
      m_kind_q   <= KIND_NOTICE;
      m_job_q    <= rd_job;
      m_rst_q    <= ~run_q[rd_job];
      m_status_q <= STAT_OK;
      m_cmd_q    <= TMR_LEAVE;
      m_ms_q     <= '0;
      m_last_q   <= 1'b0;
    end else if (emit_summary) begin
      m_kind_q   <= KIND_SUMMARY;
      m_job_q    <= '0;
      m_rst_q    <= 1'b0;
      m_status_q <= status_q;
      m_cmd_q    <= cmd_q;
      m_ms_q     <= ms_q;
      m_last_q   <= 1'b1;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tuser_o  = m_kind_q;
  assign m_axis_tlast_o  = m_last_q;
  assign m_axis_tdata_o  = {6'b0, m_ms_q, m_cmd_q, m_status_q, m_rst_q, m_job_q};

`ifndef NO_ASSERTIONS
  // Table never holds more entries than its depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(TABLE_DEPTH))
    else $error("entry count above table depth");

  // A disable command is only chosen for an empty table
  a_disable_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SUMMARY && cmd_q == TMR_DISABLE) |-> count_q == '0)
    else $error("timer disabled with entries left");

  // An insert grows the table by exactly one entry
  a_insert_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_insert |=> count_q == $past(count_q) + 1'b1)
    else $error("insert did not grow the table");

  // The last flag marks exactly the summary words
  a_last_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q |-> (m_last_q == (m_kind_q == KIND_SUMMARY)))
    else $error("last flag and kind disagree");
`endif

endmodule
